@@ hdl/per_sensor_stats_outlier_engine_assert.svh @@
// ----------------------------------------------------------------------------
// per_sensor_stats_outlier_engine_assert.svh
// assertion macros shared by the statistics engine modules
// ----------------------------------------------------------------------------
`ifndef PER_SENSOR_STATS_OUTLIER_ENGINE_ASSERT_SVH
`define PER_SENSOR_STATS_OUTLIER_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// implication checked on every clock edge outside reset
`define PSSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a result in the next cycle
`define PSSO_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);
`else
`define PSSO_ASSERT(lbl, prop, msg)
`define PSSO_ASSERT_NEXT(lbl, cond, res, msg)
`endif

`endif

@@ hdl/psso_pkg.sv @@
// ----------------------------------------------------------------------------
// psso_pkg
// shared types and constants of the per-sensor statistics engine
// ----------------------------------------------------------------------------
`default_nettype none

package psso_pkg;

  localparam int NUM_SENSORS = 1024;
  localparam int IDX_W       = $clog2(NUM_SENSORS);
  localparam int LIMB_W      = 32;
  localparam int LIMBS       = 5;
  localparam int BIG_W       = LIMB_W * LIMBS;
  localparam int MEAN_QW     = 17;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [1:0] STATUS_ALERT = 2'd1;
  localparam logic [1:0] STATUS_CRIT  = 2'd2;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [47:0] E48_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] E48_MIN    = 48'sh8000_0000_0000;

  typedef logic [BIG_W-1:0] big_t;

  typedef struct packed {
    logic               active;
    logic [31:0]        count;
    logic signed [47:0] sum;
    logic [63:0]        sq;
    logic signed [15:0] min_v;
    logic signed [15:0] max_v;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    active: 1'b0,
    count:  32'd0,
    sum:    48'sd0,
    sq:     64'd0,
    min_v:  SAMPLE_MAX,
    max_v:  SAMPLE_MIN
  };

  typedef struct packed {
    logic [31:0]        count;
    logic signed [47:0] sum;
    logic [63:0]        sq;
    logic signed [15:0] x;
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/psso_ram.sv @@
// ----------------------------------------------------------------------------
// psso_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module psso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/psso_div.sv @@
// ----------------------------------------------------------------------------
// psso_div
// mean unit: signed sum over unsigned count, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module psso_div
  import psso_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] sum,
  input  logic [31:0]        count,
  output logic               busy,
  output logic signed [15:0] mean
);

  logic                       busy_r;
  logic [$clog2(MEAN_QW)-1:0] step_r;
  logic [31:0]                rem_r;
  logic [31:0]                den_r;
  logic [MEAN_QW-1:0]         low_r;
  logic [MEAN_QW-1:0]         quo_r;
  logic                       neg_r;

  logic [47:0]        mag;
  logic [32:0]        trial;
  logic               ge;
  logic [32:0]        diff;
  logic [MEAN_QW-1:0] quo_neg;

  assign mag     = sum[47] ? (~sum + 48'd1) : sum;
  assign trial   = {rem_r, low_r[MEAN_QW-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = trial - {1'b0, den_r};
  assign quo_neg = ~quo_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == ($clog2(MEAN_QW))'(MEAN_QW - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= 32'(mag >> MEAN_QW);
      low_r  <= mag[MEAN_QW-1:0];
      quo_r  <= '0;
      neg_r  <= sum[47];
      den_r  <= count;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[31:0] : trial[31:0];
      low_r  <= {low_r[MEAN_QW-2:0], 1'b0};
      quo_r  <= {quo_r[MEAN_QW-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign mean = neg_r ? quo_neg[15:0] : quo_r[15:0];

endmodule

`default_nettype wire

@@ hdl/psso_bigmul.sv @@
// ----------------------------------------------------------------------------
// psso_bigmul
// limb-serial wide multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module psso_bigmul
  import psso_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  big_t        a,
  input  logic [2:0]  na,
  input  logic [63:0] b,
  input  logic [1:0]  nb,
  output logic        busy,
  output logic        done,
  output big_t        p
);

  logic [LIMBS-1:0][LIMB_W-1:0] a_r;
  logic [LIMBS-1:0][LIMB_W-1:0] t_r;
  logic [1:0][LIMB_W-1:0]       b_r;
  logic [2:0]                   na_r;
  logic [1:0]                   nb_r;
  logic [2:0]                   i_r;
  logic                         j_r;
  logic [LIMB_W-1:0]            carry_r;
  logic                         busy_r;
  logic                         done_r;

  logic [2:0]          k;
  logic                k_ok;
  logic [LIMB_W-1:0]   a_limb;
  logic [LIMB_W-1:0]   t_k;
  logic [2*LIMB_W-1:0] prod;
  logic [2*LIMB_W-1:0] acc;
  logic                last_i;
  logic                last_j;

  assign k      = i_r + {2'b00, j_r};
  assign k_ok   = k < 3'(LIMBS);
  assign a_limb = (i_r < na_r) ? a_r[i_r] : '0;
  assign t_k    = k_ok ? t_r[k] : '0;
  assign prod   = a_limb * b_r[j_r];
  assign acc    = {{LIMB_W{1'b0}}, t_k} + prod + {{LIMB_W{1'b0}}, carry_r};
  assign last_i = i_r == na_r;
  assign last_j = {1'b0, j_r} == (nb_r - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_i && last_j) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      b_r     <= b;
      na_r    <= na;
      nb_r    <= nb;
      t_r     <= '0;
      i_r     <= '0;
      j_r     <= 1'b0;
      carry_r <= '0;
    end else if (busy_r) begin
      if (k_ok) begin
        t_r[k] <= acc[LIMB_W-1:0];
      end
      if (last_i) begin
        i_r     <= '0;
        j_r     <= j_r + 1'b1;
        carry_r <= '0;
      end else begin
        i_r     <= i_r + 1'b1;
        carry_r <= acc[2*LIMB_W-1:LIMB_W];
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = t_r;

endmodule

`default_nettype wire

@@ hdl/psso_outlier.sv @@
// ----------------------------------------------------------------------------
// psso_outlier
// exact sigma-limit test sequenced over the shared wide multiplier
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_sensor_stats_outlier_engine_assert.svh"

module psso_outlier
  import psso_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  stat_t      op,
  input  logic [7:0] k_lim,
  output logic       busy,
  output logic       outlier
);

  localparam logic [3:0] O_IDLE = 4'd0;
  localparam logic [3:0] O_NQ   = 4'd1;
  localparam logic [3:0] O_SS   = 4'd2;
  localparam logic [3:0] O_VAR  = 4'd3;
  localparam logic [3:0] O_VN   = 4'd4;
  localparam logic [3:0] O_VK   = 4'd5;
  localparam logic [3:0] O_NX   = 4'd6;
  localparam logic [3:0] O_E    = 4'd7;
  localparam logic [3:0] O_ABS  = 4'd8;
  localparam logic [3:0] O_DD   = 4'd9;
  localparam logic [3:0] O_DL   = 4'd10;
  localparam logic [3:0] O_CMP  = 4'd11;

  logic [3:0]          state_r;
  logic                issued_r;
  logic                outlier_r;
  stat_t               op_r;
  logic [7:0]          k_r;
  logic [95:0]         nq_r;
  logic [95:0]         ss_r;
  logic [95:0]         var_r;
  logic [127:0]        vn_r;
  big_t                rk_r;
  logic [47:0]         nx_r;
  logic                nx_neg_r;
  logic signed [49:0]  e_r;
  logic [48:0]         dmag_r;
  logic [127:0]        dd_r;
  big_t                l_r;

  logic [47:0]        smag;
  logic [15:0]        xmag;
  logic [47:0]        nx_w;
  logic signed [49:0] nx_s;
  logic signed [49:0] s_s;
  logic               mul_op;
  logic               mul_start;
  logic               mul_busy;
  logic               mul_done;
  big_t               mul_a;
  logic [2:0]         mul_na;
  logic [63:0]        mul_b;
  logic [1:0]         mul_nb;
  big_t               mul_p;

  assign smag = op_r.sum[47] ? (~op_r.sum + 48'd1) : op_r.sum;
  assign xmag = op_r.x[15] ? (~op_r.x + 16'd1) : op_r.x;
  assign nx_w = op_r.count * xmag;
  assign nx_s = $signed({2'b00, nx_r});
  assign s_s  = $signed({{2{op_r.sum[47]}}, op_r.sum});

  always_comb begin
    mul_op = 1'b1;
    mul_a  = '0;
    mul_na = 3'd1;
    mul_b  = '0;
    mul_nb = 2'd1;
    unique case (state_r)
      O_NQ: begin
        mul_a  = BIG_W'(op_r.sq);
        mul_na = 3'd2;
        mul_b  = 64'(op_r.count);
      end
      O_SS: begin
        mul_a  = BIG_W'(smag);
        mul_na = 3'd2;
        mul_b  = 64'(smag);
        mul_nb = 2'd2;
      end
      O_VN: begin
        mul_a  = BIG_W'(var_r);
        mul_na = 3'd3;
        mul_b  = 64'(op_r.count);
      end
      O_VK: begin
        mul_a  = BIG_W'(vn_r);
        mul_na = 3'd4;
        mul_b  = 64'(k_r);
      end
      O_DD: begin
        mul_a  = BIG_W'(dmag_r);
        mul_na = 3'd2;
        mul_b  = 64'(dmag_r);
        mul_nb = 2'd2;
      end
      O_DL: begin
        mul_a  = BIG_W'(dd_r);
        mul_na = 3'd4;
        mul_b  = 64'(op_r.count - 32'd1);
      end
      default: mul_op = 1'b0;
    endcase
  end

  assign mul_start = mul_op && !issued_r;

  psso_bigmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .na    (mul_na),
    .b     (mul_b),
    .nb    (mul_nb),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= O_IDLE;
      issued_r  <= 1'b0;
      outlier_r <= 1'b0;
    end else begin
      if (mul_start) begin
        issued_r <= 1'b1;
      end else if (mul_done) begin
        issued_r <= 1'b0;
      end
      unique case (state_r)
        O_IDLE: begin
          if (start) begin
            outlier_r <= 1'b0;
            if (op.count >= 32'd2) begin
              state_r <= O_NQ;
            end
          end
        end
        O_NQ:  if (mul_done) state_r <= O_SS;
        O_SS:  if (mul_done) state_r <= O_VAR;
        O_VAR: state_r <= (nq_r > ss_r) ? O_VN : O_IDLE;
        O_VN:  if (mul_done) state_r <= O_VK;
        O_VK:  if (mul_done) state_r <= O_NX;
        O_NX:  state_r <= O_E;
        O_E:   state_r <= O_ABS;
        O_ABS: state_r <= O_DD;
        O_DD:  if (mul_done) state_r <= O_DL;
        O_DL:  if (mul_done) state_r <= O_CMP;
        O_CMP: begin
          outlier_r <= l_r > rk_r;
          state_r   <= O_IDLE;
        end
        default: state_r <= O_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == O_IDLE && start) begin
      op_r <= op;
      k_r  <= k_lim;
    end
    if (mul_done) begin
      case (state_r)
        O_NQ:    nq_r <= mul_p[95:0];
        O_SS:    ss_r <= mul_p[95:0];
        O_VN:    vn_r <= mul_p[127:0];
        O_VK:    rk_r <= mul_p;
        O_DD:    dd_r <= mul_p[127:0];
        O_DL:    l_r  <= mul_p;
        default: ;
      endcase
    end
    if (state_r == O_VAR) begin
      var_r <= nq_r - ss_r;
    end
    if (state_r == O_NX) begin
      nx_r     <= nx_w;
      nx_neg_r <= op_r.x[15];
    end
    if (state_r == O_E) begin
      e_r <= nx_neg_r ? (nx_s + s_s) : (nx_s - s_s);
    end
    if (state_r == O_ABS) begin
      dmag_r <= e_r[49] ? 49'(-e_r) : 49'(e_r);
    end
  end

  assign busy    = state_r != O_IDLE;
  assign outlier = outlier_r;

  `PSSO_ASSERT(a_mul_idle, mul_start |-> !mul_busy, "multiplier started while busy")
  `PSSO_ASSERT(a_start_idle, start |-> state_r == O_IDLE, "test started while busy")
  `PSSO_ASSERT_NEXT(a_cmp_ends, state_r == O_CMP, state_r == O_IDLE, "compare did not end test")

endmodule

`default_nettype wire

@@ hdl/per_sensor_stats_outlier_engine.sv @@
// ----------------------------------------------------------------------------
// per_sensor_stats_outlier_engine
// per-sensor mean, variance and sigma-limit outlier engine on a statistics ram
// ----------------------------------------------------------------------------
// One transaction is processed at a time. After reset a clearing pass writes
// every one of the 1024 table entries, one per cycle, and in_tready stays low
// until the pass ends. A skipped transaction goes from lookup straight to the
// output stage; an accumulate does a table read, update and write-back, then a
// bit-serial mean division, and a test of an active sensor is paced by the
// limb-serial 32x32 multiplier that forms the exact variance and deviation
// products. The next transaction is taken while a result still waits in the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_sensor_stats_outlier_engine_assert.svh"

module per_sensor_stats_outlier_engine
  import psso_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sensor_index [9:0], sample_value [25:10], status_code [27:26], zero pad
  input  logic [31:0]  in_tdata,
  // cmd [0], is_energy [1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sensor_mean [15:0], sensor_min [31:16], sensor_max [47:32],
  // sensor_count [79:48], alert_total [111:80], critical_total [143:112],
  // energy_total [191:144]
  output logic [191:0] out_tdata,
  // skipped [0], outlier [1]
  output logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [7:0]       SIGMA_RESET = 8'd9;
  localparam logic [IDX_W-1:0] CLR_LAST    = IDX_W'(NUM_SENSORS - 1);

  logic [2:0]         state_r;
  logic [IDX_W-1:0]   clr_addr_r;
  logic               cmd_r;
  logic               energy_r;
  logic [9:0]         idx_r;
  logic signed [15:0] x_r;
  logic [1:0]         status_r;
  logic [31:0]        xsq_r;
  logic               skip_r;
  entry_t             ent_r;
  logic               start_r;
  logic               ostart_r;
  logic [7:0]         sigma_r;
  logic [31:0]        alert_r;
  logic [31:0]        crit_r;
  logic signed [47:0] energy_sum_r;
  logic               out_tvalid_r;
  logic [191:0]       out_tdata_r;
  logic [1:0]         out_tuser_r;

  logic               in_acc;
  logic signed [15:0] in_x;
  logic signed [31:0] in_xsq;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;
  entry_t             upd;
  logic               idx_ok;
  logic               look_skip;
  logic               acc_upd;
  logic               cnt_sat;
  logic [48:0]        e_sum;
  logic signed [47:0] energy_nxt;
  logic               load_out;
  logic               div_busy;
  logic signed [15:0] div_mean;
  logic               o_busy;
  logic               o_outlier;
  stat_t              o_op;

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign in_x      = $signed(in_tdata[25:10]);
  assign in_xsq    = in_x * in_x;

  assign rd_ent    = entry_t'(ram_rdata);
  assign idx_ok    = (idx_r != 10'd0) && (32'(idx_r) < NUM_SENSORS);
  assign look_skip = !idx_ok || (cmd_r == CMD_TEST && !rd_ent.active);
  assign acc_upd   = state_r == S_LOOK && idx_ok && cmd_r == CMD_ACC;
  assign cnt_sat   = rd_ent.count == CNT_MAX;

  always_comb begin
    upd        = rd_ent;
    upd.active = 1'b1;
    if (!cnt_sat) begin
      upd.count = rd_ent.count + 32'd1;
      upd.sum   = rd_ent.sum + {{32{x_r[15]}}, x_r};
      upd.sq    = rd_ent.sq + {32'd0, xsq_r};
    end
    if (x_r < $signed(rd_ent.min_v)) begin
      upd.min_v = x_r;
    end
    if (x_r > $signed(rd_ent.max_v)) begin
      upd.max_v = x_r;
    end
  end

  assign e_sum      = {energy_sum_r[47], energy_sum_r} + {{33{x_r[15]}}, x_r};
  assign energy_nxt = (e_sum[48] != e_sum[47]) ? (e_sum[48] ? E48_MIN : E48_MAX)
                                               : $signed(e_sum[47:0]);

  assign ram_we    = state_r == S_CLR || acc_upd;
  assign ram_waddr = (state_r == S_CLR) ? clr_addr_r : IDX_W'(idx_r);
  assign ram_wdata = (state_r == S_CLR) ? ENTRY_RESET : upd;

  psso_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SENSORS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (IDX_W'(in_tdata[9:0])),
    .rdata (ram_rdata)
  );

  psso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .sum   (ent_r.sum),
    .count (ent_r.count),
    .busy  (div_busy),
    .mean  (div_mean)
  );

  assign o_op = '{count: ent_r.count, sum: ent_r.sum, sq: ent_r.sq, x: x_r};

  psso_outlier u_outlier (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ostart_r),
    .op      (o_op),
    .k_lim   (sigma_r),
    .busy    (o_busy),
    .outlier (o_outlier)
  );

  assign load_out = state_r == S_OUT && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      start_r      <= 1'b0;
      ostart_r     <= 1'b0;
      sigma_r      <= SIGMA_RESET;
      alert_r      <= '0;
      crit_r       <= '0;
      energy_sum_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      start_r  <= 1'b0;
      ostart_r <= 1'b0;
      if (cfg_wr_en) begin
        sigma_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (acc_upd) begin
        if (status_r == STATUS_ALERT && alert_r != CNT_MAX) begin
          alert_r <= alert_r + 32'd1;
        end
        if (status_r == STATUS_CRIT && crit_r != CNT_MAX) begin
          crit_r <= crit_r + 32'd1;
        end
        if (energy_r) begin
          energy_sum_r <= energy_nxt;
        end
      end
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: if (in_acc) state_r <= S_LOOK;
        S_LOOK: begin
          if (look_skip) begin
            state_r <= S_OUT;
          end else begin
            start_r  <= 1'b1;
            ostart_r <= cmd_r == CMD_TEST;
            state_r  <= S_RUN;
          end
        end
        S_RUN: if (!start_r && !div_busy && !o_busy) state_r <= S_OUT;
        S_OUT: if (load_out) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser[0];
      energy_r <= in_tuser[1];
      idx_r    <= in_tdata[9:0];
      x_r      <= in_x;
      status_r <= in_tdata[27:26];
      xsq_r    <= in_xsq;
    end
    if (state_r == S_LOOK) begin
      skip_r <= look_skip;
      ent_r  <= (cmd_r == CMD_ACC) ? upd : rd_ent;
    end
    if (load_out) begin
      out_tuser_r <= {!skip_r && cmd_r == CMD_TEST && o_outlier, skip_r};
      out_tdata_r <= {energy_sum_r, crit_r, alert_r,
                      skip_r ? 32'd0 : ent_r.count,
                      skip_r ? 16'd0 : ent_r.max_v,
                      skip_r ? 16'd0 : ent_r.min_v,
                      skip_r ? 16'd0 : div_mean};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `PSSO_ASSERT_NEXT(a_accept_look, in_tvalid && in_tready, state_r == S_LOOK, "no lookup after accept")
  `PSSO_ASSERT(a_ram_we, ram_we |-> (state_r == S_CLR || (state_r == S_LOOK && cmd_r == CMD_ACC)), "stray table write")
  `PSSO_ASSERT(a_out_flags, (out_tvalid && out_tuser[1]) |-> (!out_tuser[0] && out_tdata[79:48] >= 32'd2), "outlier without statistics")

endmodule

`default_nettype wire

@@ tb/per_sensor_stats_outlier_engine_test.sv @@
// ----------------------------------------------------------------------------
// per_sensor_stats_outlier_engine_test
// self-checking bench: directed table then random accumulate/test traffic
// ----------------------------------------------------------------------------
// Every accepted transaction runs through a behavioral model of the sensor
// table. The model predicts the result, and a queue holds the predictions in
// order for the output checker. The limit register is set to several values,
// 1 and 255 among them, while the engine is idle. The sender sends in bursts
// and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_sensor_stats_outlier_engine_test;
  import psso_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         sensor;
    logic signed [15:0] sample;
    logic [1:0]         status;
    logic               energy;
  } reading_t;

  typedef struct packed {
    logic               skipped;
    logic               outlier;
    logic signed [15:0] mean;
    logic signed [15:0] min_v;
    logic signed [15:0] max_v;
    logic [31:0]        count;
    logic [31:0]        alerts;
    logic [31:0]        crits;
    logic signed [47:0] energy;
  } verdict_t;

  typedef struct {
    reading_t rd;
    logic     known;
    verdict_t v;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;

  per_sensor_stats_outlier_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // model state
  logic               tab_active [NUM_SENSORS];
  logic [31:0]        tab_count  [NUM_SENSORS];
  logic signed [47:0] tab_sum    [NUM_SENSORS];
  logic [63:0]        tab_sq     [NUM_SENSORS];
  logic signed [15:0] tab_min    [NUM_SENSORS];
  logic signed [15:0] tab_max    [NUM_SENSORS];
  logic [31:0]        alert_cnt, crit_cnt;
  logic signed [47:0] energy_acc;
  logic [7:0]         sigma_sq;

  verdict_t pending_results[$];
  int  fails;
  int  idle_cycles;
  logic hold_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic beyond_sigma(int unsigned k, logic signed [15:0] x);
    logic [63:0]  n;
    logic signed [159:0] s, d, lhs, rhs, varnum;
    n = {32'd0, tab_count[k]};
    if (n < 2) return 1'b0;
    s = tab_sum[k];
    varnum = $signed({96'd0, n}) * $signed({96'd0, tab_sq[k]}) - s * s;
    if (varnum <= 0) return 1'b0;
    d = $signed({96'd0, n}) * x - s;
    lhs = d * d * $signed({96'd0, n - 64'd1});
    rhs = varnum * $signed({96'd0, n}) * $signed({152'd0, sigma_sq});
    return lhs > rhs;
  endfunction

  function automatic verdict_t apply_reading(reading_t r);
    verdict_t v;
    int unsigned k;
    logic signed [48:0] e;
    logic signed [47:0] q;
    k = r.sensor;
    v = '0;
    if (k == 0) begin
      v.skipped = 1'b1;
    end else if (r.cmd == CMD_ACC) begin
      tab_active[k] = 1'b1;
      if (tab_count[k] != CNT_MAX) begin
        tab_count[k] = tab_count[k] + 1;
        tab_sum[k] = tab_sum[k] + r.sample;
        tab_sq[k] = tab_sq[k] + 64'(r.sample * r.sample);
      end
      if (r.sample < tab_min[k]) tab_min[k] = r.sample;
      if (r.sample > tab_max[k]) tab_max[k] = r.sample;
      if (r.status == STATUS_ALERT && alert_cnt != CNT_MAX) alert_cnt++;
      if (r.status == STATUS_CRIT && crit_cnt != CNT_MAX) crit_cnt++;
      if (r.energy) begin
        e = energy_acc + r.sample;
        if (e > E48_MAX) e = E48_MAX;
        if (e < E48_MIN) e = E48_MIN;
        energy_acc = e[47:0];
      end
    end else if (!tab_active[k]) begin
      v.skipped = 1'b1;
    end else begin
      v.outlier = beyond_sigma(k, r.sample);
    end
    if (!v.skipped) begin
      q = (tab_count[k] == 0) ? 48'sd0 : tab_sum[k] / $signed({16'd0, tab_count[k]});
      v.mean  = q[15:0];
      v.min_v = tab_min[k];
      v.max_v = tab_max[k];
      v.count = tab_count[k];
    end
    v.alerts = alert_cnt;
    v.crits  = crit_cnt;
    v.energy = energy_acc;
    return v;
  endfunction

  task automatic send_reading(reading_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, r.status, r.sample, r.sensor};
    in_tuser  <= {r.energy, r.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_reading(r));
  endtask

  task automatic offer(reading_t r, logic known, verdict_t want);
    verdict_t got;
    send_reading(r);
    got = pending_results[$];
    if (known && got !== want) begin
      $display("%0t directed row predicted %h, table says %h", $time, got, want);
      fails++;
    end
  endtask

  task automatic gap();
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_then_write(logic [7:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    sigma_sq = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic reading_t random_reading(int unsigned hot);
    reading_t r;
    r.cmd    = ($urandom_range(0, 2) == 0) ? CMD_TEST : CMD_ACC;
    r.sensor = ($urandom_range(0, 19) == 0) ? 10'($urandom) :
               (($urandom_range(0, 29) == 0) ? 10'd0 : 10'($urandom_range(1, hot)));
    case ($urandom_range(0, 3))
      0: r.sample = 16'($urandom);
      1: r.sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: r.sample = 16'sd100 + 16'($urandom_range(0, 40)) - 16'sd20;
    endcase
    if (r.cmd == CMD_TEST && $urandom_range(0, 3) == 0)
      r.sample = 16'($urandom_range(0, 1) ? 16'sd2000 : -16'sd2000);
    r.status = 2'($urandom);
    r.energy = 1'($urandom);
    return r;
  endfunction

  // receiver stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 31) == 0);
  end

  // checker
  always @(posedge clk) begin
    verdict_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[1], out_tdata[15:0], out_tdata[31:16],
             out_tdata[47:32], out_tdata[79:48], out_tdata[111:80],
             out_tdata[143:112], out_tdata[191:144]};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.skipped !== want.skipped || got.outlier !== want.outlier ||
            got.mean !== want.mean || got.min_v !== want.min_v ||
            got.max_v !== want.max_v || got.count !== want.count ||
            got.alerts !== want.alerts || got.crits !== want.crits ||
            got.energy !== want.energy) begin
          $display("%0t expected %h, actual %h", $time, want, got);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** per_sensor_stats_outlier_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    hold_off = 1'b0;
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    verdict_t z;
    logic [7:0] limits [4];
    int n;
    limits = '{8'd1, 8'd255, 8'd4, 8'd9};
    fails = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      tab_active[i] = 1'b0; tab_count[i] = 0; tab_sum[i] = 0; tab_sq[i] = 0;
      tab_min[i] = SAMPLE_MAX; tab_max[i] = SAMPLE_MIN;
    end
    alert_cnt = 0; crit_cnt = 0; energy_acc = 0; sigma_sq = 8'd9;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    z = '0;
    // invalid index, test of inactive sensor
    rw.known = 1'b1; rw.v = z; rw.v.skipped = 1'b1;
    rw.rd = '{CMD_ACC, 10'd0, SAMPLE_MAX, STATUS_ALERT, 1'b1}; rows.push_back(rw);
    rw.rd = '{CMD_TEST, 10'd1023, SAMPLE_MIN, 2'd0, 1'b0}; rows.push_back(rw);
    // first accumulate of extremes
    rw.v = z; rw.v.mean = SAMPLE_MAX; rw.v.min_v = SAMPLE_MAX; rw.v.max_v = SAMPLE_MAX;
    rw.v.count = 1; rw.v.alerts = 1; rw.v.energy = 48'sd32767;
    rw.rd = '{CMD_ACC, 10'd1023, SAMPLE_MAX, STATUS_ALERT, 1'b1}; rows.push_back(rw);
    rw.known = 1'b0;
    rw.rd = '{CMD_ACC, 10'd1023, SAMPLE_MIN, STATUS_CRIT, 1'b1}; rows.push_back(rw);
    rw.rd = '{CMD_ACC, 10'd1, 16'sd0, 2'd3, 1'b0}; rows.push_back(rw);
    rw.rd = '{CMD_TEST, 10'd1, 16'sd5, 2'd0, 1'b0}; rows.push_back(rw);
    rw.rd = '{CMD_ACC, 10'd1, 16'sd0, 2'd0, 1'b1}; rows.push_back(rw);
    // zero variance, then a real spread
    rw.rd = '{CMD_TEST, 10'd1, 16'sd100, 2'd0, 1'b0}; rows.push_back(rw);
    for (int i = 0; i < 6; i++) begin
      rw.rd = '{CMD_ACC, 10'd2, 16'(16'sd10 + i), 2'(i), 1'(i)}; rows.push_back(rw);
    end
    rw.rd = '{CMD_TEST, 10'd2, 16'sd12, 2'd0, 1'b0}; rows.push_back(rw);
    rw.rd = '{CMD_TEST, 10'd2, SAMPLE_MAX, 2'd0, 1'b0}; rows.push_back(rw);
    rw.rd = '{CMD_TEST, 10'd2, SAMPLE_MIN, 2'd0, 1'b1}; rows.push_back(rw);
    rw.rd = '{CMD_TEST, 10'd1023, 16'sd0, 2'd0, 1'b0}; rows.push_back(rw);
    rw.rd = '{CMD_ACC, 10'd512, -16'sd7, 2'd0, 1'b1}; rows.push_back(rw);

    foreach (rows[i]) begin
      offer(rows[i].rd, rows[i].known, rows[i].v);
      gap();
    end

    for (int p = 0; p < 5; p++) begin
      if (p > 0) drain_then_write(limits[p - 1]);
      n = (p == 0) ? 500 : 200;
      for (int i = 0; i < n; i++) begin
        send_reading(random_reading(p == 0 ? 8 : 40));
        if ($urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("** per_sensor_stats_outlier_engine: PASSED **");
    end else begin
      $display("** per_sensor_stats_outlier_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
